[rtl/lcom_pkg.sv]
`default_nettype none

package lcom_pkg;

  // Field widths of the point stream and of the configuration registers.
  localparam int RANGE_W    = 20;
  localparam int RING_W     = 7;
  localparam int GAP_W      = 16;
  localparam int DIV_W      = 8;
  localparam int CURV_W     = 47;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Window geometry: HALF_WIN neighbors on each side of the scored point.
  localparam int HALF_WIN  = 5;
  localparam int WIN_DEPTH = 2 * HALF_WIN + 2;
  localparam int EMIT_SLOT = HALF_WIN + 1;

  // Arithmetic widths derived from the window size.
  localparam int SUM_W  = RANGE_W + $clog2(HALF_WIN + 1);
  localparam int MAG_W  = RANGE_W + $clog2(2 * HALF_WIN + 1);
  localparam int SQ_W   = 2 * MAG_W;
  localparam int PROD_W = RANGE_W + DIV_W;

  // Register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_GAP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIV = CFG_IDX_W'(1);
  localparam logic [GAP_W-1:0]     GAP_RESET = GAP_W'(300);
  localparam logic [DIV_W-1:0]     DIV_RESET = DIV_W'(50);

  // Input item.
  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic [RING_W-1:0]  ring_number;
    logic               last_of_cloud;
  } point_t;

  // Result item.
  typedef struct packed {
    logic [CURV_W-1:0]  curvature;
    logic               excluded;
    logic [RANGE_W-1:0] point_range;
    logic [RING_W-1:0]  point_ring;
    logic               final_result;
  } result_t;

  // Contents of one window cell.
  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic [RING_W-1:0]  ring;
    logic               mark;
    logic               last;
    logic               valid;
  } cell_t;

  // What a cell sees of its newer neighbor.
  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic [RING_W-1:0]  ring;
    logic               valid;
  } nbr_t;

  // Comparison of a cell against its newer neighbor.
  typedef struct packed {
    logic same;
    logic up;
    logic down;
  } step_t;

  // Snapshot of the window around the scored point, handed to the scoring pipeline.
  typedef struct packed {
    logic [HALF_WIN-1:0][RANGE_W-1:0] newer;
    logic [HALF_WIN-1:0][RANGE_W-1:0] older;
    logic [RANGE_W-1:0]               range_mm;
    logic [RING_W-1:0]                ring;
    logic                             last;
    logic                             edge_pt;
    logic                             occl;
  } job_t;

endpackage

`default_nettype wire

[rtl/lcom_cell.sv]
`default_nettype none

module lcom_cell import lcom_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             shift,
  input  wire logic             clear,
  input  wire logic [GAP_W-1:0] gap,
  input  wire cell_t            load,
  input  wire nbr_t             nbr,
  output cell_t                 state,
  output step_t                 step
);

  logic               valid;
  logic [RANGE_W-1:0] range_q;
  logic [RING_W-1:0]  ring_q;
  logic               mark_q;
  logic               last_q;
  logic [RANGE_W:0]   rise;
  logic [RANGE_W:0]   fall;

  // Occupancy of the cell; cleared at reset and at the end of a sweep.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= load.valid;
    end
  end

  // Point data moves one cell older on every shift.
  always_ff @(posedge clk) begin
    if (shift) begin
      range_q <= load.range_mm;
      ring_q  <= load.ring;
      mark_q  <= load.mark;
      last_q  <= load.last;
    end
  end

  assign state = '{range_mm: range_q, ring: ring_q, mark: mark_q, last: last_q, valid: valid};

  // Range jumps against the newer neighbor, only within one ring.
  assign rise = {1'b0, nbr.range_mm} - {1'b0, range_q};
  assign fall = {1'b0, range_q} - {1'b0, nbr.range_mm};

  assign step.same = valid & nbr.valid & (ring_q == nbr.ring);
  assign step.up   = step.same & ~rise[RANGE_W] & (rise[RANGE_W-1:0] > RANGE_W'(gap));
  assign step.down = step.same & ~fall[RANGE_W] & (fall[RANGE_W-1:0] > RANGE_W'(gap));

endmodule

`default_nettype wire

[rtl/lcom_eval.sv]
`default_nettype none

module lcom_eval import lcom_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             job_valid,
  input  wire job_t             job,
  output logic                  job_ready,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output result_t               result
);

  function automatic logic [RANGE_W-1:0] absdiff(input logic [RANGE_W-1:0] a,
                                                 input logic [RANGE_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic               s1_v;
  logic [SUM_W-1:0]   s1_left;
  logic [SUM_W-1:0]   s1_right;
  logic [MAG_W-1:0]   s1_ten_r;
  logic [RANGE_W-1:0] s1_dprev;
  logic [RANGE_W-1:0] s1_dnext;
  logic [RANGE_W-1:0] s1_range;
  logic [RING_W-1:0]  s1_ring;
  logic               s1_last;
  logic               s1_edge;
  logic               s1_occl;

  logic               s2_v;
  logic [MAG_W-1:0]   s2_mag;
  logic [PROD_W-1:0]  s2_p_prev;
  logic [PROD_W-1:0]  s2_p_next;
  logic [RANGE_W-1:0] s2_range;
  logic [RING_W-1:0]  s2_ring;
  logic               s2_last;
  logic               s2_edge;
  logic               s2_occl;

  logic               s1_free;
  logic               s2_free;
  logic               s3_free;
  logic [SUM_W-1:0]   left_sum;
  logic [SUM_W-1:0]   right_sum;
  logic [MAG_W:0]     acc;
  logic [MAG_W:0]     acc_neg;
  logic [SQ_W-1:0]    sq;
  logic               parallel;

  // A stage takes new data when it is empty or its contents move on.
  assign s3_free   = ~result_valid | ~result_stall;
  assign s2_free   = ~s2_v | s3_free;
  assign s1_free   = ~s1_v | s2_free;
  assign job_ready = s1_free;

  // Neighbor sums on each side of the scored point.
  always_comb begin
    left_sum  = '0;
    right_sum = '0;
    for (int k = 0; k < HALF_WIN; k++) begin
      left_sum  = left_sum + SUM_W'(job.newer[k]);
      right_sum = right_sum + SUM_W'(job.older[k]);
    end
  end

  // Stage 1: sums, scaled own range and the two neighbor differences.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_free) begin
      s1_v <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_left  <= left_sum;
      s1_right <= right_sum;
      s1_ten_r <= MAG_W'(job.range_mm) * MAG_W'(2 * HALF_WIN);
      s1_dprev <= absdiff(job.newer[0], job.range_mm);
      s1_dnext <= absdiff(job.older[0], job.range_mm);
      s1_range <= job.range_mm;
      s1_ring  <= job.ring;
      s1_last  <= job.last;
      s1_edge  <= job.edge_pt;
      s1_occl  <= job.occl;
    end
  end

  // Stage 2: signed difference, its magnitude and the parallel-beam products.
  assign acc     = (MAG_W+1)'(s1_left) + (MAG_W+1)'(s1_right) - (MAG_W+1)'(s1_ten_r);
  assign acc_neg = (MAG_W+1)'(0) - acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_free) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_mag    <= acc[MAG_W] ? acc_neg[MAG_W-1:0] : acc[MAG_W-1:0];
      s2_p_prev <= PROD_W'(s1_dprev) * PROD_W'(divisor);
      s2_p_next <= PROD_W'(s1_dnext) * PROD_W'(divisor);
      s2_range  <= s1_range;
      s2_ring   <= s1_ring;
      s2_last   <= s1_last;
      s2_edge   <= s1_edge;
      s2_occl   <= s1_occl;
    end
  end

  // Stage 3: square and final flag, held in the output register.
  assign sq       = SQ_W'(s2_mag) * SQ_W'(s2_mag);
  assign parallel = (s2_p_prev > PROD_W'(s2_range)) & (s2_p_next > PROD_W'(s2_range));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s3_free) begin
      result_valid <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free) begin
      result.curvature    <= s2_edge ? '0 : CURV_W'(sq);
      result.excluded     <= s2_edge | s2_occl | parallel;
      result.point_range  <= s2_range;
      result.point_ring   <= s2_ring;
      result.final_result <= s2_last;
    end
  end

endmodule

`default_nettype wire

[rtl/lidar_curvature_occlusion_marker_top.sv]
// Throughput: one point per cycle while point_stall is low. A point with last_of_cloud
// set is followed by internal shift cycles that drain the window, during which no new
// point is taken. A point is scored once six newer points have entered (or the sweep
// ends); its result then passes through the scoring pipeline into the output register.
// Reset (synchronous, rst high) empties the window and the scoring pipeline and loads
// the occlusion gap with 300 mm and the parallel-beam divisor with 50.
`default_nettype none

module lidar_curvature_occlusion_marker_top import lcom_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  point_valid,
  output logic                       point_stall,
  input  wire point_t                point,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [GAP_W-1:0] gap;
  logic [DIV_W-1:0] divisor;
  logic             pend;
  logic             flushing;

  cell_t cells [WIN_DEPTH];
  cell_t loads [WIN_DEPTH];
  nbr_t  nbrs  [WIN_DEPTH];
  step_t steps [WIN_DEPTH];

  job_t  job;
  logic  job_ready;
  logic  job_take;
  logic  can_shift;
  logic  accept;
  logic  bubble;
  logic  shift;
  logic  finish;

  // Configuration registers; a write is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap     <= GAP_RESET;
      divisor <= DIV_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAP: gap     <= cfg_data[GAP_W-1:0];
        REG_DIV: divisor <= cfg_data[DIV_W-1:0];
      endcase
    end
  end

  // The window shifts on an accepted point, or on an empty slot while the sweep drains.
  // It holds while the scored point has not yet been taken by the pipeline.
  assign job_take    = pend & job_ready;
  assign can_shift   = ~pend | job_take;
  assign point_stall = flushing | ~can_shift;
  assign accept      = point_valid & ~point_stall;
  assign bubble      = flushing & can_shift;
  assign shift       = accept | bubble;
  assign finish      = job_take & cells[EMIT_SLOT].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      flushing <= 1'b0;
    end else begin
      priority if (finish) begin
        pend     <= 1'b0;
        flushing <= 1'b0;
      end else if (shift) begin
        pend     <= cells[EMIT_SLOT-1].valid;
        flushing <= flushing | (accept & point.last_of_cloud);
      end else if (job_take) begin
        pend <= 1'b0;
      end
    end
  end

  // Feed of each cell: the head takes the new point (or an empty slot while draining),
  // every other cell takes its newer neighbor.
  always_comb begin
    nbrs[0]  = '{range_mm: point.range_mm, ring: point.ring_number, valid: ~flushing};
    loads[0] = '{range_mm: point.range_mm, ring: point.ring_number, mark: steps[0].up,
                 last: point.last_of_cloud, valid: ~flushing};
    for (int k = 1; k < WIN_DEPTH; k++) begin
      nbrs[k]  = '{range_mm: cells[k-1].range_mm, ring: cells[k-1].ring,
                   valid: cells[k-1].valid};
      loads[k] = cells[k-1];
    end
  end

  // Row of window cells, newest first.
  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    lcom_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .clear (finish),
      .gap   (gap),
      .load  (loads[k]),
      .nbr   (nbrs[k]),
      .state (cells[k]),
      .step  (steps[k])
    );
  end

  // Snapshot around the scored cell: ring edges, near-side drops and far-side marks.
  always_comb begin
    job.range_mm = cells[EMIT_SLOT].range_mm;
    job.ring     = cells[EMIT_SLOT].ring;
    job.last     = cells[EMIT_SLOT].last;
    for (int k = 0; k < HALF_WIN; k++) begin
      job.newer[k] = cells[EMIT_SLOT-1-k].range_mm;
      job.older[k] = cells[EMIT_SLOT+1+k].range_mm;
    end
    job.edge_pt = 1'b0;
    for (int k = 2; k < WIN_DEPTH; k++) begin
      job.edge_pt = job.edge_pt | ~steps[k].same;
    end
    job.occl = 1'b0;
    for (int k = 1; k <= EMIT_SLOT; k++) begin
      job.occl = job.occl | steps[k].down;
    end
    for (int k = EMIT_SLOT; k < WIN_DEPTH; k++) begin
      job.occl = job.occl | cells[k].mark;
    end
  end

  // Scoring pipeline with the output register.
  lcom_eval u_eval (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (pend),
    .job          (job),
    .job_ready    (job_ready),
    .divisor      (divisor),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
